// ===== design/c2s_pkg.sv =====
// Shared constants and types for the Cartesian-to-spherical converter.
package c2s_pkg;
  localparam int Steps = 16;
  localparam int VecW = 28;   // working width of CORDIC vector components
  localparam int AccW = 26;   // angle accumulator, 2^-15 degree units
  localparam int RootW = 24;  // cos magnitude width
  localparam int RadW = 48;   // sqrt radicand width

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [AccW-1:0] acc_t;

  function automatic acc_t atan_entry(input logic [3:0] i);
    acc_t r;
    r = '0;
    case (i)
      4'd0: r = 26'sd1474560;
      4'd1: r = 26'sd870484;
      4'd2: r = 26'sd459940;
      4'd3: r = 26'sd233473;
      4'd4: r = 26'sd117189;
      4'd5: r = 26'sd58652;
      4'd6: r = 26'sd29333;
      4'd7: r = 26'sd14667;
      4'd8: r = 26'sd7334;
      4'd9: r = 26'sd3667;
      4'd10: r = 26'sd1833;
      4'd11: r = 26'sd917;
      4'd12: r = 26'sd458;
      4'd13: r = 26'sd229;
      4'd14: r = 26'sd115;
      4'd15: r = 26'sd57;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== design/c2s_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage, enable-driven.
module c2s_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [c2s_pkg::RadW-1:0] rad,
  output logic [c2s_pkg::RootW-1:0] root
);
  localparam int N = c2s_pkg::RootW;
  logic [c2s_pkg::RadW-1:0] rem [0:N];
  logic [N-1:0] rt [0:N];

  assign rem[0] = rad;
  assign rt[0] = '0;

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [c2s_pkg::RadW-1:0] trial;
    logic [c2s_pkg::RadW-1:0] rem_n;
    logic [N-1:0] rt_n;
    // trial for root bit k = N-1-s: 2*root*2^k + 2^(2k)
    always_comb begin
      trial = ({{(c2s_pkg::RadW-N){1'b0}}, rt[s]} << (N-s))
            | ({{(c2s_pkg::RadW-1){1'b0}}, 1'b1} << (2*(N-1-s)));
      if (rem[s] >= trial) begin
        rem_n = rem[s] - trial;
        rt_n = rt[s] | (N'(1) << (N-1-s));
      end else begin
        rem_n = rem[s];
        rt_n = rt[s];
      end
    end
    logic [c2s_pkg::RadW-1:0] rem_q;
    logic [N-1:0] rt_q;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_n;
        rt_q <= rt_n;
      end
    end
    assign rem[s+1] = rem_q;
    assign rt[s+1] = rt_q;
  end
  assign root = rt[N];
endmodule

// ===== design/c2s_cordic.sv =====
// Pipelined CORDIC vectoring engine, one micro-rotation per stage.
module c2s_cordic (
  input  logic clk,
  input  logic en,
  input  c2s_pkg::vec_t a_in,
  input  c2s_pkg::vec_t b_in,
  input  c2s_pkg::acc_t acc_in,
  output c2s_pkg::acc_t acc_out
);
  localparam int N = c2s_pkg::Steps;
  c2s_pkg::vec_t a [0:N];
  c2s_pkg::vec_t b [0:N];
  c2s_pkg::acc_t t [0:N];
  assign a[0] = a_in;
  assign b[0] = b_in;
  assign t[0] = acc_in;

  for (genvar s = 0; s < N; s++) begin : g_st
    c2s_pkg::vec_t a_q, b_q;
    c2s_pkg::acc_t t_q;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!b[s][c2s_pkg::VecW-1]) begin
          a_q <= a[s] + (b[s] >>> s);
          b_q <= b[s] - (a[s] >>> s);
          t_q <= t[s] + c2s_pkg::atan_entry(4'(s));
        end else begin
          a_q <= a[s] - (b[s] >>> s);
          b_q <= b[s] + (a[s] >>> s);
          t_q <= t[s] - c2s_pkg::atan_entry(4'(s));
        end
      end
    end
    assign a[s+1] = a_q;
    assign b[s+1] = b_q;
    assign t[s+1] = t_q;
  end
  assign acc_out = t[N];
endmodule

// ===== design/cartesian_to_spherical.sv =====
// Top level: direction vector to azimuth/elevation pipeline.
// Fully pipelined converter: one vector per clock while the output is not stalled,
// 43 register stages (1 input stage, 24 square-root stages for cos(elevation),
// 16 CORDIC stages, 1 round stage, 1 output register). Azimuth = atan2(x,-z) in
// [0,360] deg, elevation =
// asin(y), both in 1/128 deg. The whole pipe advances when the output register
// is empty or being taken, so a stall freezes all stages and loses nothing.
module cartesian_to_spherical (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [47:0] s_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [31:0] m_tdata    // azimuth[15:0], elevation[30:16], zero[31]
);
  localparam int Lat = 1 + c2s_pkg::RootW + c2s_pkg::Steps + 2;
  localparam int VW = c2s_pkg::VecW;

  logic en;
  logic [Lat-1:0] vld;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [15:0] dx, dy, dz;
  assign dx = s_tdata[15:0];
  assign dy = s_tdata[31:16];
  assign dz = s_tdata[47:32];

  // input stage: azimuth setup (half-plane fold) and sqrt radicand
  c2s_pkg::vec_t az_a, az_b;
  c2s_pkg::acc_t az_base;
  logic az_zero;
  c2s_pkg::vec_t y_s;
  logic [c2s_pkg::RadW-1:0] rad;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [VW-1:0] x8, f8;
      logic signed [31:0] ysq;
      x8 = VW'(dx) <<< 8;
      f8 = -(VW'(dz) <<< 8);
      az_zero <= (dx == 0) && (dz == 0);
      if (f8 < 0) begin
        az_a <= -f8;
        az_b <= -x8;
        az_base <= c2s_pkg::acc_t'(180 * 32768);
      end else begin
        az_a <= f8;
        az_b <= x8;
        az_base <= '0;
      end
      y_s <= VW'(dy) <<< 8;
      ysq = dy * dy;
      rad <= (48'd1 << 46) - {ysq[31:0], 16'd0};
    end
  end

  // delay azimuth inputs, y and the zero flag across sqrt latency
  c2s_pkg::vec_t da [0:c2s_pkg::RootW];
  c2s_pkg::vec_t db [0:c2s_pkg::RootW];
  c2s_pkg::vec_t dyv [0:c2s_pkg::RootW];
  c2s_pkg::acc_t dbase [0:c2s_pkg::RootW];
  logic dz0 [0:c2s_pkg::RootW];
  assign da[0] = az_a;
  assign db[0] = az_b;
  assign dyv[0] = y_s;
  assign dbase[0] = az_base;
  assign dz0[0] = az_zero;
  for (genvar i = 0; i < c2s_pkg::RootW; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        da[i+1] <= da[i];
        db[i+1] <= db[i];
        dyv[i+1] <= dyv[i];
        dbase[i+1] <= dbase[i];
        dz0[i+1] <= dz0[i];
      end
    end
  end

  logic [c2s_pkg::RootW-1:0] cosv;
  c2s_sqrt u_sqrt (.clk, .en, .rad, .root(cosv));

  c2s_pkg::acc_t az_t, el_t;
  c2s_cordic u_az (.clk, .en, .a_in(da[c2s_pkg::RootW]), .b_in(db[c2s_pkg::RootW]),
    .acc_in(dbase[c2s_pkg::RootW]), .acc_out(az_t));
  c2s_cordic u_el (.clk, .en, .a_in(VW'(cosv)), .b_in(dyv[c2s_pkg::RootW]),
    .acc_in('0), .acc_out(el_t));

  logic zq [0:c2s_pkg::Steps];
  assign zq[0] = dz0[c2s_pkg::RootW];
  for (genvar i = 0; i < c2s_pkg::Steps; i++) begin : g_zq
    always_ff @(posedge clk) if (en) zq[i+1] <= zq[i];
  end

  // round stage
  logic [15:0] az_r;
  logic signed [14:0] el_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c2s_pkg::acc_t t, r, e;
      t = az_t;
      if (t < 0) t = t + c2s_pkg::acc_t'(360 * 32768);
      r = (t + 26'sd128) >>> 8;
      if (zq[c2s_pkg::Steps] || r < 0) az_r <= '0;
      else if (r > 26'sd46080) az_r <= 16'd46080;
      else az_r <= r[15:0];
      e = (el_t + 26'sd128) >>> 8;
      if (e > 26'sd11520) el_r <= 15'sd11520;
      else if (e < -26'sd11520) el_r <= -15'sd11520;
      else el_r <= e[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[Lat-1];

  logic [15:0] az_o;
  logic [14:0] el_o;
  always_ff @(posedge clk) begin
    if (en) begin
      az_o <= az_r;
      el_o <= el_r;
    end
  end
  assign m_tdata = {1'b0, el_o, az_o};

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
  a_az_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> az_o <= 16'd46080)
    else $error("azimuth out of range");
  a_el_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(el_o) <= 15'sd11520 && $signed(el_o) >= -15'sd11520))
    else $error("elevation out of range");
endmodule

// ===== tb/sv/c2s_checker.sv =====
// Checker: watches both streams, predicts azimuth/elevation and compares.
module c2s_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] azimuth;
    logic [14:0] elevation;
  } angles_t;

  angles_t angles_q[$];

  localparam longint OneDeg = 32768;
  localparam longint AtanTab [16] = '{1474560, 870484, 459940, 233473, 117189, 58652,
    29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  function automatic longint vec_angle(longint a, longint b);
    longint acc, da, db;
    acc = 0;
    for (int i = 0; i < 16; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; acc += AtanTab[i];
      end else begin
        a -= da; b += db; acc -= AtanTab[i];
      end
    end
    return acc;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic angles_t to_angles(logic [47:0] d);
    longint x, y, fwd, az, el, t, base, cosv;
    angles_t r;
    x = longint'($signed(d[15:0])) * 256;
    y = longint'($signed(d[31:16])) * 256;
    fwd = -longint'($signed(d[47:32])) * 256;
    if (x == 0 && fwd == 0) begin
      az = 0;
    end else begin
      base = 0;
      // facing backward: turn by half a circle first
      if (fwd < 0) begin
        fwd = -fwd; x = -x; base = 180 * OneDeg;
      end
      t = base + vec_angle(fwd, x);
      if (t < 0) t += 360 * OneDeg;
      az = (t + 128) >>> 8;
      if (az < 0) az = 0;
      if (az > 46080) az = 46080;
    end
    cosv = int_sqrt((64'd1 << 46) - longint'(y * y));
    el = (vec_angle(cosv, y) + 128) >>> 8;
    if (el > 11520) el = 11520;
    if (el < -11520) el = -11520;
    r.azimuth = az[15:0];
    r.elevation = el[14:0];
    return r;
  endfunction

  always @(posedge clk) begin
    angles_t exp_a;
    int n;
    n = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) angles_q.push_back(to_angles(s_tdata));
      if (m_tvalid && m_tready) begin
        if (angles_q.size() == 0) begin
          $error("unexpected word %h", m_tdata);
          n++;
        end else begin
          exp_a = angles_q.pop_front();
          if (m_tdata[15:0] !== exp_a.azimuth) begin
            $error("azimuth expected %0d got %0d", exp_a.azimuth, m_tdata[15:0]);
            n++;
          end
          if (m_tdata[30:16] !== exp_a.elevation) begin
            $error("elevation expected %0d got %0d", $signed(exp_a.elevation),
                   $signed(m_tdata[30:16]));
            n++;
          end
        end
      end
      errors <= errors + n;
    end
    pending <= angles_q.size();
  end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives direction vectors and a stalling sink, gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;        // azimuth[15:0], elevation[30:16], zero[31]
  int          errors, pending;
  int          cycles = 0;
  int          stall_left = 0;
  bit          sink_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  cartesian_to_spherical DUT (.*);
  c2s_checker checker_i (.*);

  // generous limit: 850 words, each with a random idle gap and sink stall, plus pipe
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // sink: after each taken word, hold ready low for a randomly drawn stall, often none
  always @(posedge clk) begin
    int w;
    if (sink_on) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= (stall_left == 1);
      end else if (m_tvalid && m_tready) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (w > 0) begin
          m_tready <= 0;
          stall_left <= w;
        end
      end else begin
        m_tready <= 1;
      end
    end
  end

  // drive one word after the given idle gap, hold valid until taken;
  // called at a rising edge, returns at the accepting edge
  task automatic send_word(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input int gap);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {z, y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dv [8];
    int gap;
    dv = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h4000, 16'hC000, 16'h5A82};
    repeat (6) @(posedge clk);
    rst <= 0;
    sink_on = 1;
    // directed: zero x-z vector, backward axis, near 360, y extremes
    send_word(16'h0000, 16'h0000, 16'h0000, 0);
    send_word(16'h0000, 16'h7FFF, 16'h0000, 0);
    send_word(16'h0000, 16'h8000, 16'h0000, 0);
    send_word(16'hFFFF, 16'h0000, 16'h8000, 0);
    send_word(16'hFFFF, 16'h0000, 16'hFFFF, 0);
    send_word(16'h8000, 16'h0000, 16'h7FFF, 0);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_word(16'h8000, 16'h8000, 16'h8000, 0);
    send_word(16'h0001, 16'h0001, 16'h0000, 0);
    send_word(16'h0000, 16'hFFFF, 16'h0001, 0);
    for (int i = 0; i < 8; i++) send_word(dv[i], dv[7 - i], dv[(i + 3) % 8], 0);
    s_tvalid <= 0;
    // pause until the pipe drains completely
    wait (pending == 0);
    @(posedge clk);
    for (int i = 0; i < 850; i++) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (i >= 300 && i < 400) gap = 0;   // back-to-back stretch
      send_word(rand_comp(), rand_comp(), rand_comp(), gap);
    end
    s_tvalid <= 0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
